@@ hw/rtl/mbe_pkg.sv @@
// shared constants, types and helpers of the mandelbrot escape-time pixel core
package mbe_pkg;

  localparam int FIX_W     = 48;
  localparam int STEP_W    = 45;
  localparam int ITER_W    = 16;
  localparam int SHADE_W   = 4;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_MAX_COLUMNS = 1024;
  localparam int DEF_MAX_ROWS    = 1024;
  localparam int DEF_FRAC_BITS   = 44;

  localparam logic signed [FIX_W-1:0] FIX_MAX = {1'b0, {(FIX_W-1){1'b1}}};
  localparam logic signed [FIX_W-1:0] FIX_MIN = {1'b1, {(FIX_W-1){1'b0}}};

  // reset values: -2.0, 1.5, about 2/528 and 400
  localparam logic signed [FIX_W-1:0] RST_RE_LEFT  = 48'hE000_0000_0000;
  localparam logic signed [FIX_W-1:0] RST_IM_TOP   = 48'h1800_0000_0000;
  localparam logic [STEP_W-1:0]       RST_STEP     = 45'd66633278958;
  localparam logic [ITER_W-1:0]       RST_LIMIT    = 16'd400;

  localparam logic [SHADE_W-1:0] SHADE_LAST = 4'd9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RE_LEFT    = 2'd0,
    CFG_IM_TOP     = 2'd1,
    CFG_STEP       = 2'd2,
    CFG_ITER_LIMIT = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CMUL_RE,
    ST_CMUL_IM,
    ST_CADD_IM,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_TEST,
    ST_UPD1,
    ST_UPD2,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    OP_SQ_RE,
    OP_SQ_IM,
    OP_CROSS
  } mul_op_e;

  typedef struct packed {
    logic                    start;
    logic signed [FIX_W-1:0] a;
    logic signed [FIX_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [FIX_W-1:0] p;
  } mul_rsp_t;

  // clamp a one-bit-grown sum back to the fixed-point range
  function automatic logic signed [FIX_W-1:0] sat_fix(input logic signed [FIX_W:0] v);
    logic signed [FIX_W-1:0] r;
    if (v[FIX_W] != v[FIX_W-1]) begin
      r = v[FIX_W] ? FIX_MIN : FIX_MAX;
    end else begin
      r = v[FIX_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/mbe_if.sv @@
// pixel request and pixel result channel interfaces
interface mbe_pix_if import mbe_pkg::*; #(
  parameter int COL_W = $clog2(DEF_MAX_COLUMNS),
  parameter int ROW_W = $clog2(DEF_MAX_ROWS)
);
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;

  modport source (output valid, col, row, input ready);
  modport sink   (input valid, col, row, output ready);
endinterface

interface mbe_res_if import mbe_pkg::*;;
  logic               valid;
  logic               ready;
  logic [SHADE_W-1:0] shade;
  logic [ITER_W-1:0]  iterations;
  logic               escaped;

  modport source (output valid, shade, iterations, escaped, input ready);
  modport sink   (input valid, shade, iterations, escaped, output ready);
endinterface

@@ hw/rtl/mbe_fmul.sv @@
// iterative fixed-point multiplier: four 24x24 partial products, floor and saturate
module mbe_fmul import mbe_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  localparam int HALF   = FIX_W / 2;
  localparam int PROD_W = 2 * FIX_W;

  logic                    run_q, fin_q, done_q;
  logic [1:0]              cnt_q;
  logic                    neg_q;
  logic [FIX_W-1:0]        ua_q, ub_q;
  logic [PROD_W-1:0]       acc_q;
  logic signed [FIX_W-1:0] p_q;

  logic [FIX_W-1:0]        ua_in, ub_in;
  logic [HALF-1:0]         opa, opb;
  logic [FIX_W-1:0]        pp;
  logic [PROD_W-1:0]       pp_sh;
  logic [PROD_W-1:0]       q;
  logic                    rem;
  logic [PROD_W:0]         mag;
  logic signed [FIX_W-1:0] res;

  localparam logic [PROD_W:0]   NEG_LIM = (PROD_W+1)'(1) << (FIX_W - 1);
  localparam logic [PROD_W-1:0] POS_LIM = {{(PROD_W-FIX_W){1'b0}}, FIX_MAX};

  assign ua_in = req_i.a[FIX_W-1] ? FIX_W'(-req_i.a) : FIX_W'(req_i.a);
  assign ub_in = req_i.b[FIX_W-1] ? FIX_W'(-req_i.b) : FIX_W'(req_i.b);

  // cnt bit 0 picks the half of a, bit 1 the half of b
  assign opa = cnt_q[0] ? ua_q[FIX_W-1:HALF] : ua_q[HALF-1:0];
  assign opb = cnt_q[1] ? ub_q[FIX_W-1:HALF] : ub_q[HALF-1:0];
  assign pp  = opa * opb;

  always_comb begin
    unique case (cnt_q)
      2'd0:       pp_sh = PROD_W'(pp);
      2'd1, 2'd2: pp_sh = PROD_W'(pp) << HALF;
      default:    pp_sh = PROD_W'(pp) << FIX_W;
    endcase
  end

  // floor of the signed product: magnitude rounds up when negative
  assign q   = acc_q >> FRAC_BITS;
  assign rem = |acc_q[FRAC_BITS-1:0];
  assign mag = {1'b0, q} + (PROD_W+1)'(rem);

  always_comb begin
    if (neg_q) begin
      res = (mag > NEG_LIM) ? FIX_MIN : FIX_W'(-mag[FIX_W-1:0]);
    end else begin
      res = (q > POS_LIM) ? FIX_MAX : q[FIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          run_q <= 1'b0;
          fin_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.a[FIX_W-1] ^ req_i.b[FIX_W-1];
      ua_q  <= ua_in;
      ub_q  <= ub_in;
      acc_q <= '0;
    end else if (run_q) begin
      acc_q <= acc_q + pp_sh;
    end
    if (fin_q) begin
      p_q <= res;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.p    = p_q;

endmodule

@@ hw/rtl/mandelbrot_escape_time_pixel_core.sv @@
// Mandelbrot escape-time pixel core: one pixel in, one iteration count out.
// A pixel beat carries col and row; the core forms c = (re_left + col*step,
// im_top - row*step), clamped to signed Q4.44 (FRAC_BITS fraction bits),
// starts from z = c and repeats z = z*z + c until |z|^2 > 4 or the count reaches
// iteration_limit. The result beat gives the count, an escaped flag and the
// shade (count mod 10). Every product is floor-rounded and saturated, every sum
// saturated. All 48-bit products go through one shared multiplier that builds
// each product from four 24x24 partial products; one iteration needs three
// products plus three add/compare steps. The core takes one pixel at a time:
// in_i.ready is high only while idle, while a finished result may still wait
// in the output register.
// Registers (re_left, im_top, step, iteration_limit) are written through
// cfg_we_i/cfg_idx_i/cfg_data_i and must only change while the core is idle.
module mandelbrot_escape_time_pixel_core import mbe_pkg::*; #(
  parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [FIX_W-1:0]     cfg_data_i,
  mbe_pix_if.sink              in_i,
  mbe_res_if.source            out_o
);

  localparam int COL_W   = $clog2(DEF_MAX_COLUMNS);
  localparam int ROW_W   = $clog2(DEF_MAX_ROWS);
  localparam int CR_W    = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int CPROD_W = CR_W + STEP_W;
  localparam int CSUM_W  = CPROD_W + 4;
  localparam int SQ_W    = 64;

  localparam logic signed [SQ_W-1:0] FOUR = 64'sd4 <<< FRAC_BITS;

  // clamp a coordinate sum to the fixed-point range
  function automatic logic signed [FIX_W-1:0] sat_coord(input logic signed [CSUM_W-1:0] v);
    logic [CSUM_W-FIX_W:0]   hi;
    logic signed [FIX_W-1:0] r;
    hi = v[CSUM_W-1:FIX_W-1];
    if (&hi || ~|hi) begin
      r = v[FIX_W-1:0];
    end else begin
      r = v[CSUM_W-1] ? FIX_MIN : FIX_MAX;
    end
    return r;
  endfunction

  // configuration registers
  logic signed [FIX_W-1:0] re_left_q, im_top_q;
  logic [STEP_W-1:0]       step_q;
  logic [ITER_W-1:0]       limit_q;

  // sequencer
  state_e  state_q, state_d;
  mul_op_e op_q, op_d;
  logic    first_q, first_d;

  // iteration state
  logic [ITER_W-1:0]       count_q, count_d;
  logic [SHADE_W-1:0]      shade_q, shade_d;
  logic                    esc_q, esc_d;
  logic [COL_W-1:0]        col_q;
  logic [ROW_W-1:0]        row_q;
  logic [CPROD_W-1:0]      cprod_q;
  logic signed [FIX_W-1:0] cre_q, cim_q, re_q, im_q;
  logic signed [FIX_W-1:0] rr_q, ii_q, ri_q, tre_q, tim_q;

  // result register
  logic                    out_valid_q, out_valid_d;
  logic                    out_load;
  logic [SHADE_W-1:0]      out_shade_q;
  logic [ITER_W-1:0]       out_iter_q;
  logic                    out_esc_q;

  // datapath
  logic [CR_W-1:0]          cmul_op;
  logic [CPROD_W-1:0]       cprod;
  logic signed [CSUM_W-1:0] cre_sum, cim_sum;
  logic signed [SQ_W-1:0]   sq_sum;
  logic                     escape;
  logic [ITER_W:0]          count_inc;
  logic                     more;
  logic [SHADE_W-1:0]       shade_inc;
  logic                     in_beat;
  mul_req_t                 mul_req;
  mul_rsp_t                 mul_rsp;

  assign in_beat = in_i.valid & in_i.ready;

  // shared coordinate multiplier: column first, then row
  assign cmul_op = (state_q == ST_CMUL_RE) ? CR_W'(col_q) : CR_W'(row_q);
  assign cprod   = CPROD_W'(cmul_op * step_q);

  assign cre_sum = $signed({{(CSUM_W-FIX_W){re_left_q[FIX_W-1]}}, re_left_q})
                 + $signed({{(CSUM_W-CPROD_W){1'b0}}, cprod_q});
  assign cim_sum = $signed({{(CSUM_W-FIX_W){im_top_q[FIX_W-1]}}, im_top_q})
                 - $signed({{(CSUM_W-CPROD_W){1'b0}}, cprod_q});

  // escape test on the squares of the freshly updated z
  assign sq_sum = $signed({{(SQ_W-FIX_W){rr_q[FIX_W-1]}}, rr_q})
                + $signed({{(SQ_W-FIX_W){ii_q[FIX_W-1]}}, ii_q});
  assign escape = sq_sum > FOUR;

  assign count_inc = {1'b0, count_q} + (ITER_W+1)'(1);
  assign more      = count_inc < {1'b0, limit_q};
  assign shade_inc = (shade_q == SHADE_LAST) ? '0 : shade_q + SHADE_W'(1);

  // shared fixed-point multiplier
  assign mul_req.start = (state_q == ST_MUL_GO);
  assign mul_req.a     = (op_q == OP_SQ_IM) ? im_q : re_q;
  assign mul_req.b     = (op_q == OP_SQ_RE) ? re_q : im_q;

  mbe_fmul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_fmul (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mul_req),
    .rsp_o (mul_rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_i.valid) state_d = ST_CMUL_RE;
      ST_CMUL_RE:  state_d = ST_CMUL_IM;
      ST_CMUL_IM:  state_d = ST_CADD_IM;
      ST_CADD_IM:  state_d = (limit_q < ITER_W'(2)) ? ST_DONE : ST_MUL_GO;
      ST_MUL_GO:   state_d = ST_MUL_WAIT;
      ST_MUL_WAIT: begin
        if (mul_rsp.done) begin
          priority case (op_q)
            OP_CROSS: state_d = ST_UPD1;
            OP_SQ_RE: state_d = ST_MUL_GO;
            default:  state_d = ST_TEST;
          endcase
        end
      end
      ST_TEST: begin
        priority if (first_q) begin
          state_d = ST_MUL_GO;
        end else if (escape) begin
          state_d = ST_DONE;
        end else if (more) begin
          state_d = ST_MUL_GO;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_UPD1:     state_d = ST_UPD2;
      ST_UPD2:     state_d = ST_MUL_GO;
      ST_DONE:     if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs: operation select, count, shade, escape flag, result load
  always_comb begin
    op_d     = op_q;
    first_d  = first_q;
    count_d  = count_q;
    shade_d  = shade_q;
    esc_d    = esc_q;
    out_load = 1'b0;
    unique case (state_q)
      ST_CADD_IM: begin
        op_d    = OP_SQ_RE;
        first_d = 1'b1;
        count_d = ITER_W'(1);
        shade_d = SHADE_W'(1);
        esc_d   = 1'b0;
      end
      ST_MUL_WAIT: begin
        if (mul_rsp.done && op_q == OP_SQ_RE) begin
          op_d = OP_SQ_IM;
        end
      end
      ST_TEST: begin
        priority if (first_q) begin
          first_d = 1'b0;
          op_d    = OP_CROSS;
        end else if (escape) begin
          esc_d = 1'b1;
        end else begin
          count_d = count_inc[ITER_W-1:0];
          shade_d = shade_inc;
          op_d    = OP_CROSS;
        end
      end
      ST_UPD2:  op_d = OP_SQ_RE;
      ST_DONE:  out_load = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  assign out_valid_d = out_load | (out_valid_q & ~out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_SQ_RE;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
      re_left_q   <= RST_RE_LEFT;
      im_top_q    <= RST_IM_TOP;
      step_q      <= RST_STEP;
      limit_q     <= RST_LIMIT;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_RE_LEFT:    re_left_q  <= cfg_data_i;
          CFG_IM_TOP:     im_top_q   <= cfg_data_i;
          CFG_STEP:       step_q     <= cfg_data_i[STEP_W-1:0];
          CFG_ITER_LIMIT: limit_q    <= cfg_data_i[ITER_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    count_q <= count_d;
    shade_q <= shade_d;
    esc_q   <= esc_d;
    if (in_beat) begin
      col_q <= in_i.col;
      row_q <= in_i.row;
    end
    if (state_q == ST_CMUL_RE || state_q == ST_CMUL_IM) begin
      cprod_q <= cprod;
    end
    if (state_q == ST_CMUL_IM) begin
      cre_q <= sat_coord(cre_sum);
      re_q  <= sat_coord(cre_sum);
    end
    if (state_q == ST_CADD_IM) begin
      cim_q <= sat_coord(cim_sum);
      im_q  <= sat_coord(cim_sum);
    end
    if (state_q == ST_MUL_WAIT && mul_rsp.done) begin
      unique case (op_q)
        OP_SQ_RE: rr_q <= mul_rsp.p;
        OP_SQ_IM: ii_q <= mul_rsp.p;
        OP_CROSS: ri_q <= mul_rsp.p;
        default: ;
      endcase
    end
    if (state_q == ST_UPD1) begin
      tre_q <= sat_fix({rr_q[FIX_W-1], rr_q} - {ii_q[FIX_W-1], ii_q});
      tim_q <= sat_fix({ri_q, 1'b0});
    end
    if (state_q == ST_UPD2) begin
      re_q <= sat_fix({tre_q[FIX_W-1], tre_q} + {cre_q[FIX_W-1], cre_q});
      im_q <= sat_fix({tim_q[FIX_W-1], tim_q} + {cim_q[FIX_W-1], cim_q});
    end
    if (out_load) begin
      out_shade_q <= shade_q;
      out_iter_q  <= count_q;
      out_esc_q   <= esc_q;
    end
  end

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.shade      = out_shade_q;
  assign out_o.iterations = out_iter_q;
  assign out_o.escaped    = out_esc_q;

endmodule

@@ sim/mbe_escape_checker.sv @@
// escape-time checker: watches both channels, predicts each pixel's count and compares
module mbe_escape_checker import mbe_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [FIX_W-1:0]     cfg_data_i,
  mbe_pix_if                   pix_i,
  mbe_res_if                   res_i,
  output int                   errors_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     COL_W       = $clog2(DEF_MAX_COLUMNS);
  localparam int     ROW_W       = $clog2(DEF_MAX_ROWS);
  localparam longint FIX_HI      = longint'(FIX_MAX);
  localparam longint FIX_LO      = longint'(FIX_MIN);
  localparam longint FOUR        = longint'(4) <<< FRAC_BITS;

  typedef struct packed {
    logic [SHADE_W-1:0] shade;
    logic [ITER_W-1:0]  iterations;
    logic               escaped;
  } pix_result_t;

  // shadow copy of the register file
  longint      re_left_q;
  longint      im_top_q;
  longint      step_q;
  int unsigned limit_q;

  pix_result_t expected_counts[$];
  pix_result_t want;
  int          beat_no;

  function automatic longint clamp_fix(input longint v);
    if (v > FIX_HI) return FIX_HI;
    if (v < FIX_LO) return FIX_LO;
    return v;
  endfunction

  // floor-rounded, saturated fixed-point product
  function automatic longint fix_mul(input longint a, input longint b);
    logic signed [95:0] wa, wb, q, hi, lo;
    wa = a;
    wb = b;
    hi = FIX_HI;
    lo = FIX_LO;
    q  = (wa * wb) >>> FRAC_BITS;
    if (q > hi) return FIX_HI;
    if (q < lo) return FIX_LO;
    return longint'(q);
  endfunction

  function automatic pix_result_t escape_time(input logic [COL_W-1:0] col,
                                              input logic [ROW_W-1:0] row);
    longint      cre, cim, zr, zi, nr, ni;
    int unsigned n;
    bit          esc;
    pix_result_t r;
    cre = clamp_fix(re_left_q + longint'(col) * step_q);
    cim = clamp_fix(im_top_q - longint'(row) * step_q);
    zr  = cre;
    zi  = cim;
    n   = 1;
    esc = 1'b0;
    // z = c itself is never tested
    while (n < limit_q && !esc) begin
      nr = clamp_fix(clamp_fix(fix_mul(zr, zr) - fix_mul(zi, zi)) + cre);
      ni = clamp_fix(clamp_fix(2 * fix_mul(zr, zi)) + cim);
      zr = nr;
      zi = ni;
      if (fix_mul(zr, zr) + fix_mul(zi, zi) > FOUR) esc = 1'b1;
      else n++;
    end
    r.shade      = SHADE_W'(n % 10);
    r.iterations = ITER_W'(n);
    r.escaped    = esc;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint exp_v);
    $display("[%0t] result beat %0d: %0s got %0d, expected %0d",
             $time, beat_no, what, got, exp_v);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      re_left_q  = longint'(RST_RE_LEFT);
      im_top_q   = longint'(RST_IM_TOP);
      step_q     = longint'(RST_STEP);
      limit_q    = RST_LIMIT;
      expected_counts.delete();
      errors_o   = 0;
      pending_o  = 0;
      beat_no    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_RE_LEFT:    re_left_q  = longint'($signed(cfg_data_i));
          CFG_IM_TOP:     im_top_q   = longint'($signed(cfg_data_i));
          CFG_STEP:       step_q     = longint'(cfg_data_i[STEP_W-1:0]);
          CFG_ITER_LIMIT: limit_q    = cfg_data_i[ITER_W-1:0];
          default: ;
        endcase
      end
      if (pix_i.valid && pix_i.ready) begin
        expected_counts.push_back(escape_time(pix_i.col, pix_i.row));
      end
      if (res_i.valid && res_i.ready) begin
        if (expected_counts.size() == 0) begin
          report_mismatch("unexpected beat, iterations", res_i.iterations, 0);
        end else begin
          want = expected_counts.pop_front();
          if (res_i.iterations !== want.iterations)
            report_mismatch("iterations", res_i.iterations, want.iterations);
          if (res_i.escaped !== want.escaped)
            report_mismatch("escaped", res_i.escaped, want.escaped);
          if (res_i.shade !== want.shade)
            report_mismatch("shade", res_i.shade, want.shade);
        end
        beat_no++;
      end
      pending_o = expected_counts.size();
    end
  end

endmodule

@@ sim/tb.sv @@
// testbench top: drives pixel beats and register writes into the escape-time core
module tb import mbe_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COL_W         = $clog2(DEF_MAX_COLUMNS);
  localparam int ROW_W         = $clog2(DEF_MAX_ROWS);
  localparam int HOLD_CYCLES   = 4000;  // longer than two pixels at the random limits
  localparam int SETTLE_CYCLES = 32;    // core is idle once its last result beat is taken
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_ITEMS   = 185;
  localparam int WILD_PHASE    = 5;     // registers fully random in this phase
  // slowest correct run: ~1500 pixels at limits up to 40, a few pixels at limit 400,
  // two long hold-offs, all at 4 ns -> well under 8 ms
  localparam int TIMEOUT_NS    = 40_000_000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [FIX_W-1:0]     cfg_data;
  int                   errors;
  int                   pending;

  // knobs shared by the pixel source and the result sink
  int unsigned hold_reqs     = 0;
  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;

  mbe_pix_if pix_if ();
  mbe_res_if res_if ();

  mandelbrot_escape_time_pixel_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (pix_if),
    .out_o      (res_if)
  );

  mbe_escape_checker escape_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_i      (pix_if),
    .res_i      (res_if),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // hard stop if the core hangs
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("FAIL");
    $finish;
  end

  // result sink: random back-pressure, plus a long hold-off on request
  // that it times itself so the source keeps pushing meanwhile
  initial begin : result_sink
    int unsigned holds_done;
    holds_done   = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_reqs != holds_done) begin
        holds_done   = hold_reqs;
        res_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      res_if.ready = ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // one pixel beat; entered and left at a falling edge with valid low
  task automatic send_pixel(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
    while ($urandom_range(0, 99) < src_idle_pct) @(negedge clk_i);
    pix_if.valid = 1'b1;
    pix_if.col   = col;
    pix_if.row   = row;
    do @(posedge clk_i); while (!pix_if.ready);
    @(negedge clk_i);
    pix_if.valid = 1'b0;
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [FIX_W-1:0] data);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(negedge clk_i);
    cfg_we   = 1'b0;
  endtask

  task automatic program_view(input logic [FIX_W-1:0] re, input logic [FIX_W-1:0] im,
                              input logic [STEP_W-1:0] st, input logic [ITER_W-1:0] lim);
    write_reg(CFG_RE_LEFT, re);
    write_reg(CFG_IM_TOP, im);
    write_reg(CFG_STEP, FIX_W'(st));
    write_reg(CFG_ITER_LIMIT, FIX_W'(lim));
  endtask

  // every result beat in, then let the core settle back to idle
  task automatic drain_results();
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin : stimulus
    logic [63:0] r_re, r_im, r_st;
    longint      re_l, im_l, st_l;

    cfg_we       = 1'b0;
    cfg_idx      = CFG_RE_LEFT;
    cfg_data     = '0;
    pix_if.valid = 1'b0;
    pix_if.col   = '0;
    pix_if.row   = '0;
    rst_ni       = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset view: corners, the origin (inside, full 400 count) and one near the edge
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd528, 10'd396);
    send_pixel(10'd200, 10'd300);

    // limit below two: no iteration runs at all
    drain_results();
    write_reg(CFG_ITER_LIMIT, FIX_W'(0));
    send_pixel(10'd5, 10'd5);
    send_pixel(10'd1000, 10'd17);
    drain_results();
    write_reg(CFG_ITER_LIMIT, FIX_W'(1));
    send_pixel(10'd512, 10'd512);

    // top limit with saturated coordinates, so every pixel escapes at once
    drain_results();
    program_view(FIX_MAX, FIX_MIN, '1, '1);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd1, 10'd0);

    // opposite corner of the number range, widest step, smallest limit that runs an iteration
    drain_results();
    program_view(FIX_MIN, FIX_MAX, '1, 16'd2);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd512, 10'd700);

    // c = -2 sits on |z|^2 == 4 forever: equal to four is not an escape
    drain_results();
    program_view(RST_RE_LEFT, '0, '0, 16'd20);
    send_pixel(10'd0, 10'd0);

    // origin with zero step at limit two: runs out the limit
    drain_results();
    program_view('0, '0, '0, 16'd2);
    send_pixel(10'd1023, 10'd0);

    // random phases: new view each time, idle pattern rotates
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain_results();
      if (ph == WILD_PHASE) begin
        r_re = {$urandom, $urandom};
        r_im = {$urandom, $urandom};
        r_st = {$urandom, $urandom};
        program_view(r_re[FIX_W-1:0], r_im[FIX_W-1:0], r_st[STEP_W-1:0],
                     ITER_W'($urandom_range(2, 40)));
      end else begin
        // left edge in [-2.5, -0.5], top in [0.5, 1.5], spacing about 2^-11..2^-8
        re_l = -(longint'(5) <<< 43) + (longint'($urandom_range(0, 32'h4000_0000)) <<< 15);
        im_l = (longint'(1) <<< 43) + (longint'($urandom_range(0, 32'h4000_0000)) <<< 14);
        st_l = longint'($urandom_range(32'h0020_0000, 32'h0100_0000)) <<< 12;
        program_view(re_l[FIX_W-1:0], im_l[FIX_W-1:0], st_l[STEP_W-1:0],
                     ITER_W'($urandom_range(2, 40)));
      end
      case (ph % 4)
        0: begin
          src_idle_pct  = 0;
          snk_stall_pct = 0;
        end
        1: begin
          src_idle_pct  = 59;
          snk_stall_pct = 0;
        end
        2: begin
          src_idle_pct  = 0;
          snk_stall_pct = 59;
        end
        default: begin
          src_idle_pct  = 23;
          snk_stall_pct = 23;
        end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // long sink hold-off while pixels keep coming: output register fills, input stalls
        if (k == 10 && ph % 4 == 0) hold_reqs++;
        // source pauses until the core has handed back everything
        if (k == PHASE_ITEMS / 2) drain_results();
        send_pixel(COL_W'($urandom_range(0, 1023)), ROW_W'($urandom_range(0, 1023)));
      end
    end

    drain_results();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/mbe_pkg.sv
hw/rtl/mbe_if.sv
hw/rtl/mbe_fmul.sv
hw/rtl/mandelbrot_escape_time_pixel_core.sv
sim/mbe_escape_checker.sv
sim/tb.sv
